### hdl/dpu_pkg.sv
// dpu_pkg: shared types, command codes and request/response payloads for the
// dispersive pole update core. No dependencies.
package dpu_pkg;

	typedef enum logic [1:0] {
		CMD_UPDATE = 2'd0,
		CMD_FIELD  = 2'd1,
		CMD_COEF   = 2'd2,
		CMD_NOP    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CW_CFR = 2'd0,
		CW_CFI = 2'd1,
		CW_CER = 2'd2,
		CW_CEI = 2'd3
	} coef_which_t;

	typedef struct packed {
		logic [1:0]         cmd;
		logic [11:0]        cell_req;
		logic [3:0]         mat_x;
		logic [3:0]         mat_y;
		logic [3:0]         mat_z;
		logic signed [31:0] e_x;
		logic signed [31:0] e_y;
		logic signed [31:0] e_z;
		logic [3:0]         coef_material;
		logic [1:0]         coef_which;
		logic signed [31:0] coef_value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] pole_new_real_x;
		logic signed [31:0] pole_new_real_y;
		logic signed [31:0] pole_new_real_z;
		logic signed [31:0] pole_new_imag_x;
		logic signed [31:0] pole_new_imag_y;
		logic signed [31:0] pole_new_imag_z;
		logic signed [31:0] field_out_x;
		logic signed [31:0] field_out_y;
		logic signed [31:0] field_out_z;
	} rsp_t;

	// one component's coefficient set
	typedef struct packed {
		logic signed [31:0] cfr;
		logic signed [31:0] cfi;
		logic signed [31:0] cer;
		logic signed [31:0] cei;
	} coef_set_t;

	// saturate a wide signed value to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
		logic signed [66:0] hi;
		logic signed [66:0] lo;
		hi = 67'sd2147483647;
		lo = -67'sd2147483648;
		if (v > hi)
			sat32 = 32'sh7fffffff;
		else if (v < lo)
			sat32 = 32'sh80000000;
		else
			sat32 = v[31:0];
	endfunction

endpackage

### hdl/dpu_ram.sv
// dpu_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module dpu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### hdl/dpu_pole_math.sv
// dpu_pole_math: pipelined complex pole recursion for one component.
// Depends on dpu_pkg. Steps: products (registered), sums (registered), round/saturate.
module dpu_pole_math import dpu_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  coef_set_t          coef,
	input  logic signed [31:0] fr,
	input  logic signed [31:0] fi,
	input  logic signed [31:0] e,
	output logic signed [31:0] nr,
	output logic signed [31:0] ni
);
	logic signed [63:0] p_rr_s1, p_ri_s1, p_er_s1, p_ir_s1, p_ii_s1, p_ei_s1;
	logic signed [65:0] sum_r_s2, sum_i_s2;
	logic signed [66:0] rnd_r, rnd_i;

	// hold all stages when the output side stalls
	always_ff @(posedge clk) begin
		if (en) begin
			p_rr_s1 <= coef.cfr * fr;
			p_ri_s1 <= coef.cfi * fi;
			p_er_s1 <= coef.cer * e;
			p_ir_s1 <= coef.cfr * fi;
			p_ii_s1 <= coef.cfi * fr;
			p_ei_s1 <= coef.cei * e;
			sum_r_s2 <= 66'(p_rr_s1) - 66'(p_ri_s1) + 66'(p_er_s1);
			sum_i_s2 <= 66'(p_ir_s1) + 66'(p_ii_s1) + 66'(p_ei_s1);
		end
	end

	// round half up then floor by 2^30
	assign rnd_r = (67'(sum_r_s2) + 67'sd536870912) >>> 30;
	assign rnd_i = (67'(sum_i_s2) + 67'sd536870912) >>> 30;
	assign nr = sat32(rnd_r);
	assign ni = sat32(rnd_i);
endmodule

### hdl/dispersive_pole_update_core.sv
// dispersive_pole_update_core: top level of the dispersive FDTD pole update.
// Depends on dpu_pkg, dpu_ram and dpu_pole_math.
//
// One request per clock is accepted when no stall or clearing pass holds it
// off, and each gives one response, which goes through s1, s2 and s3 to the
// response register. Stage s1 reads the auxiliary memories (one per component
// and part) and the coefficient RAMs (one per component and coefficient, each
// a full mirror of the table). The edge into s2 forms the products, the edge
// into s3 the sums, and s3 rounds, saturates and writes back. The edge out of
// s3 registers the response. A read of a cell that an update in s3 will write
// takes that update's result directly. A read of a cell written at the edge
// that issued the read takes the word held from that write, because a RAM
// read issued in the cycle of the write returns the old word. An update or a
// field read of a cell that an update in s2 is still working on cannot be
// served, because that result is not yet formed. Hold it in s1 for one cycle
// and send a bubble into s2. So a dependent request that directly follows an
// update of the same cell waits for that bubble. Any other mix of requests
// runs at one per clock while the output is not stalled. The whole pipeline
// holds while the response register is full and not taken. After reset a
// clearing pass writes zero to every auxiliary entry; it takes no request.
// The coefficient table has no reset and must be written before any material
// is used. A cell at or above CELLS gives an all-zero response and changes
// nothing. A material at or above MATERIALS uses zero coefficients.
module dispersive_pole_update_core import dpu_pkg::*; #(
	parameter int CELLS     = 4096,
	parameter int MATERIALS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  req_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output rsp_t out_data
);
	localparam int CW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int TD = MATERIALS * 4;
	localparam int TW = $clog2(TD);

	typedef struct packed {
		logic [1:0]  cmd;
		logic        inr;    // cell in range
		logic [CW-1:0] cidx;
		logic [2:0]  mok;    // material in range per component
		logic signed [31:0] ex, ey, ez;
	} ctl_t;

	ctl_t ctl_s1, ctl_s2, ctl_s3;
	logic vld_s1, vld_s2, vld_s3;
	logic clr_q;
	logic [CW-1:0] clr_cnt_q;
	logic fw1_q;
	logic [CW-1:0] fw1_cidx_q;
	logic [3:0] mat_s1 [3];
	logic signed [31:0] fld_r_s2 [3];
	logic signed [31:0] fld_r_s3 [3];
	rsp_t rsp_d;

	wire signed [31:0] nr [3];
	wire signed [31:0] ni [3];
	wire signed [31:0] fr_s1 [3];
	wire signed [31:0] fi_s1 [3];
	wire signed [31:0] e_s1 [3];
	wire [3:0] mat_in [3];
	wire [31:0] cdat [3][4];

	logic adv, acc, ld, cell_ok, hz_stall, hz3, hz4, wb, coef_we, aux_we;
	logic [TW-1:0] coef_wa;
	logic [CW-1:0] aux_wa;

	function automatic logic mat_ok(input logic [3:0] m);
		mat_ok = 32'(m) < MATERIALS;
	endfunction

	// pipeline advances unless the response register is held
	assign adv = !out_valid || out_ready;

	// dependent request in s1 behind an update of the same cell in s2
	assign hz_stall = vld_s1 && ctl_s1.inr &&
		(ctl_s1.cmd == CMD_UPDATE || ctl_s1.cmd == CMD_FIELD) &&
		vld_s2 && ctl_s2.cmd == CMD_UPDATE && ctl_s2.inr && ctl_s2.cidx == ctl_s1.cidx;

	assign in_ready = adv && !clr_q && !hz_stall;
	assign acc = in_valid && in_ready;
	assign ld = adv && !hz_stall;
	assign cell_ok = 32'(in_data.cell_req) < CELLS;

	// clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + CW'(1);
			if (32'(clr_cnt_q) == CELLS - 1)
				clr_q <= 1'b0;
		end
	end

	// pipeline control: hold s1 and drop a bubble into s2 on a dependency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			if (!hz_stall)
				vld_s1 <= acc;
			vld_s2 <= vld_s1 && !hz_stall;
			vld_s3 <= vld_s2;
			out_valid <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			ctl_s1.cmd  <= in_data.cmd;
			ctl_s1.inr  <= cell_ok;
			ctl_s1.cidx <= CW'(in_data.cell_req);
			ctl_s1.mok  <= {mat_ok(in_data.mat_z), mat_ok(in_data.mat_y),
				mat_ok(in_data.mat_x)};
			ctl_s1.ex   <= in_data.e_x;
			ctl_s1.ey   <= in_data.e_y;
			ctl_s1.ez   <= in_data.e_z;
			mat_s1[0]   <= in_data.mat_x;
			mat_s1[1]   <= in_data.mat_y;
			mat_s1[2]   <= in_data.mat_z;
		end
		if (adv) begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			fld_r_s2 <= fr_s1;
			fld_r_s3 <= fld_r_s2;
		end
	end

	// coefficient write
	assign coef_we = acc && in_data.cmd == CMD_COEF && mat_ok(in_data.coef_material);
	assign coef_wa = TW'({in_data.coef_material, in_data.coef_which});

	// write back at s3 (math result valid combinationally at s3)
	assign wb = adv && vld_s3 && ctl_s3.cmd == CMD_UPDATE && ctl_s3.inr;
	assign aux_wa = clr_q ? clr_cnt_q : ctl_s3.cidx;
	assign aux_we = clr_q || wb;

	assign mat_in[0] = in_data.mat_x;
	assign mat_in[1] = in_data.mat_y;
	assign mat_in[2] = in_data.mat_z;
	assign e_s1[0] = ctl_s1.ex;
	assign e_s1[1] = ctl_s1.ey;
	assign e_s1[2] = ctl_s1.ez;

	// forwarding sources for the entry read in s1
	assign hz3 = vld_s3 && ctl_s3.cmd == CMD_UPDATE && ctl_s3.inr && ctl_s3.cidx == ctl_s1.cidx;
	assign hz4 = fw1_q && fw1_cidx_q == ctl_s1.cidx;

	// late forwarding: registered copy of the last write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fw1_q <= 1'b0;
		else
			fw1_q <= wb;
	end

	always_ff @(posedge clk) begin
		if (wb)
			fw1_cidx_q <= ctl_s3.cidx;
	end

	genvar g, w;
	generate
		for (g = 0; g < 3; g++) begin : g_comp
			logic signed [31:0] fw1_r_q, fw1_i_q;
			logic signed [31:0] rd_r, rd_i;
			logic [CW-1:0] aux_ra;
			coef_set_t cs;

			// re-read the held cell while s1 waits
			assign aux_ra = ld ? CW'(in_data.cell_req) : ctl_s1.cidx;

			dpu_ram #(.WIDTH(32), .DEPTH(CELLS)) u_re (
				.clk, .we(aux_we), .waddr(aux_wa), .wdata(clr_q ? 32'd0 : nr[g]),
				.raddr(aux_ra), .rdata(rd_r));
			dpu_ram #(.WIDTH(32), .DEPTH(CELLS)) u_im (
				.clk, .we(aux_we), .waddr(aux_wa), .wdata(clr_q ? 32'd0 : ni[g]),
				.raddr(aux_ra), .rdata(rd_i));
			for (w = 0; w < 4; w++) begin : g_cf
				dpu_ram #(.WIDTH(32), .DEPTH(TD)) u_cf (
					.clk, .we(coef_we), .waddr(coef_wa), .wdata(in_data.coef_value),
					.raddr(ld ? TW'({mat_in[g], 2'(w)}) : TW'({mat_s1[g], 2'(w)})),
					.rdata(cdat[g][w]));
			end

			always_ff @(posedge clk) begin
				if (wb) begin
					fw1_r_q <= nr[g];
					fw1_i_q <= ni[g];
				end
			end

			// newest in-flight write wins
			assign fr_s1[g] = hz3 ? nr[g] : (hz4 ? fw1_r_q : rd_r);
			assign fi_s1[g] = hz3 ? ni[g] : (hz4 ? fw1_i_q : rd_i);

			always_comb begin
				cs.cfr = ctl_s1.mok[g] ? cdat[g][0] : 32'd0;
				cs.cfi = ctl_s1.mok[g] ? cdat[g][1] : 32'd0;
				cs.cer = ctl_s1.mok[g] ? cdat[g][2] : 32'd0;
				cs.cei = ctl_s1.mok[g] ? cdat[g][3] : 32'd0;
			end

			dpu_pole_math u_math (
				.clk, .en(adv), .coef(cs), .fr(fr_s1[g]), .fi(fi_s1[g]),
				.e(e_s1[g]), .nr(nr[g]), .ni(ni[g]));
		end
	endgenerate

	// response: zero in every field that the command does not produce
	always_comb begin
		rsp_d = '0;
		if (vld_s3 && ctl_s3.inr && ctl_s3.cmd == CMD_UPDATE) begin
			rsp_d.pole_new_real_x = nr[0];
			rsp_d.pole_new_real_y = nr[1];
			rsp_d.pole_new_real_z = nr[2];
			rsp_d.pole_new_imag_x = ni[0];
			rsp_d.pole_new_imag_y = ni[1];
			rsp_d.pole_new_imag_z = ni[2];
		end else if (vld_s3 && ctl_s3.inr && ctl_s3.cmd == CMD_FIELD) begin
			rsp_d.field_out_x = sat32(67'(ctl_s3.ex) + 67'(fld_r_s3[0]));
			rsp_d.field_out_y = sat32(67'(ctl_s3.ey) + 67'(fld_r_s3[1]));
			rsp_d.field_out_z = sat32(67'(ctl_s3.ez) + 67'(fld_r_s3[2]));
		end
	end

	// response register
	always_ff @(posedge clk) begin
		if (adv)
			out_data <= rsp_d;
	end

	// no request while clearing
	a_clr_block: assert property (@(posedge clk) disable iff (!arst_n)
		clr_q |-> !in_ready) else $error("request taken during clear");
	// response register holds while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("response lost on stall");
	// write-back only outside the clearing pass
	a_wb: assert property (@(posedge clk) disable iff (!arst_n)
		wb |-> !clr_q) else $error("write-back during clear");
	// a dependent request stays put in s1 for the bubble
	a_dep_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hz_stall && adv |=> vld_s1 && $stable(ctl_s1))
		else $error("dependent request moved on");
endmodule

### sim/dpu_pole_checker.sv
// dpu_pole_checker: watches the request and response channels of the pole update core,
// predicts every response from its own copy of the cell and coefficient state,
// and compares. Depends on dpu_pkg.
module dpu_pole_checker import dpu_pkg::*; (
	input  logic clk,
	input  logic in_valid,
	input  logic in_ready,
	input  req_t in_data,
	input  logic out_valid,
	input  logic out_ready,
	input  rsp_t out_data,
	output int   errors,
	output int   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [31:0] aux_re [3][4096];
	logic signed [31:0] aux_im [3][4096];
	logic signed [31:0] coefs [64];
	rsp_t rsp_q [$];

	initial begin
		errors = 0;
		pending = 0;
		for (int c = 0; c < 3; c++) begin
			for (int n = 0; n < 4096; n++) begin
				aux_re[c][n] = '0;
				aux_im[c][n] = '0;
			end
		end
		for (int n = 0; n < 64; n++)
			coefs[n] = '0;
	end

	// round half up from Q14.54 back to Q8.24, then clamp
	function automatic logic signed [31:0] rescale(input logic signed [67:0] acc);
		logic signed [67:0] t;
		t = (acc + (68'sd1 <<< 29)) >>> 30;
		if (t > 68'sd2147483647)
			return 32'sh7fffffff;
		if (t < -68'sd2147483648)
			return 32'sh80000000;
		return t[31:0];
	endfunction

	function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] s;
		s = a + b;
		if (s > 33'sd2147483647)
			return 32'sh7fffffff;
		if (s < -33'sd2147483648)
			return 32'sh80000000;
		return s[31:0];
	endfunction

	// advance one component of one cell; results land in nr/ni
	task automatic advance_pole(input int comp, input int idx, input logic [3:0] mat,
			input logic signed [31:0] e, output logic signed [31:0] nr,
			output logic signed [31:0] ni);
		logic signed [31:0] cfr, cfi, cer, cei, fr, fi;
		logic signed [67:0] acc;
		cfr = coefs[{mat, CW_CFR}];
		cfi = coefs[{mat, CW_CFI}];
		cer = coefs[{mat, CW_CER}];
		cei = coefs[{mat, CW_CEI}];
		fr = aux_re[comp][idx];
		fi = aux_im[comp][idx];
		acc = cfr * fr - cfi * fi + cer * e;
		nr = rescale(acc);
		acc = cfr * fi + cfi * fr + cei * e;
		ni = rescale(acc);
		aux_re[comp][idx] = nr;
		aux_im[comp][idx] = ni;
	endtask

	task automatic predict_response(input req_t r);
		rsp_t p;
		int idx;
		p = '0;
		idx = r.cell_req;
		case (cmd_t'(r.cmd))
			CMD_UPDATE: begin
				advance_pole(0, idx, r.mat_x, r.e_x, p.pole_new_real_x, p.pole_new_imag_x);
				advance_pole(1, idx, r.mat_y, r.e_y, p.pole_new_real_y, p.pole_new_imag_y);
				advance_pole(2, idx, r.mat_z, r.e_z, p.pole_new_real_z, p.pole_new_imag_z);
			end
			CMD_FIELD: begin
				p.field_out_x = add_sat(r.e_x, aux_re[0][idx]);
				p.field_out_y = add_sat(r.e_y, aux_re[1][idx]);
				p.field_out_z = add_sat(r.e_z, aux_re[2][idx]);
			end
			CMD_COEF: coefs[{r.coef_material, r.coef_which}] = r.coef_value;
			default: ;
		endcase
		rsp_q.push_back(p);
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		errors++;
		$display("%0t: %s got %h want %h", $realtime, what, got, want);
	endtask

	task automatic compare_field(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report(what, got, want);
	endtask

	always @(posedge clk) begin
		rsp_t w;
		if (in_valid && in_ready)
			predict_response(in_data);
		if (out_valid && out_ready) begin
			if (rsp_q.size() == 0) begin
				report("unexpected response", out_data.pole_new_real_x, '0);
			end else begin
				w = rsp_q.pop_front();
				compare_field("pole_new_real_x", out_data.pole_new_real_x, w.pole_new_real_x);
				compare_field("pole_new_real_y", out_data.pole_new_real_y, w.pole_new_real_y);
				compare_field("pole_new_real_z", out_data.pole_new_real_z, w.pole_new_real_z);
				compare_field("pole_new_imag_x", out_data.pole_new_imag_x, w.pole_new_imag_x);
				compare_field("pole_new_imag_y", out_data.pole_new_imag_y, w.pole_new_imag_y);
				compare_field("pole_new_imag_z", out_data.pole_new_imag_z, w.pole_new_imag_z);
				compare_field("field_out_x", out_data.field_out_x, w.field_out_x);
				compare_field("field_out_y", out_data.field_out_y, w.field_out_y);
				compare_field("field_out_z", out_data.field_out_z, w.field_out_z);
			end
		end
		pending = rsp_q.size();
	end

endmodule

### sim/dispersive_pole_update_core_tb.sv
// dispersive_pole_update_core_tb: stimulus and verdict for the pole update core.
// Depends on dpu_pkg, the core RTL and dpu_pole_checker.
module dispersive_pole_update_core_tb;
	import dpu_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_REQS = 520;
	// clearing pass plus ~600 requests each with worst gaps and stalls, many times over
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;
	int errors;
	int pending;
	int cycles = 0;
	int n_update = 0, n_field = 0, n_coef = 0, n_nop = 0;
	bit quiet = 1'b0;

	// a handful of hot cells so updates land back to back on the same address
	logic [11:0] hot_cells [8] = '{12'd0, 12'd1, 12'd2, 12'd7, 12'd100, 12'd2048,
		12'd4094, 12'd4095};

	always #6 clk = ~clk;

	dispersive_pole_update_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	dpu_pole_checker u_checker (
		.clk      (clk),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.errors   (errors),
		.pending  (pending)
	);

	// watchdog: a hung pipeline or a lost response ends here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d responses outstanding", cycles, pending);
			$display("end of test: mismatches");
			$finish;
		end
	end

	// response side: stall a random number of cycles before each response,
	// except during quiet stretches where ready stays high
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			stall = quiet ? 0 : $urandom_range(0, 11);
			if (stall != 0) begin
				out_ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// present one request after an idle gap and hold it until taken
	task automatic send_request(input req_t r, input int gap);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data = r;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		case (cmd_t'(r.cmd))
			CMD_UPDATE: n_update++;
			CMD_FIELD:  n_field++;
			CMD_COEF:   n_coef++;
			default:    n_nop++;
		endcase
	endtask

	function automatic req_t noise_req(input cmd_t c);
		req_t r;
		logic [191:0] bits;
		bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		r = bits[$bits(req_t)-1:0];
		r.cmd = c;
		return r;
	endfunction

	function automatic logic signed [31:0] pick_coef();
		logic signed [31:0] v;
		v = $urandom;
		// mostly magnitudes below one so the recursion does not pin at the rails
		if ($urandom_range(0, 3) != 0)
			v = v >>> $urandom_range(1, 6);
		return v;
	endfunction

	function automatic logic signed [31:0] pick_field();
		logic signed [31:0] v;
		case ($urandom_range(0, 9))
			0: v = 32'sh7fffffff;
			1: v = 32'sh80000000;
			2: v = 32'sh0;
			3, 4: v = $urandom;
			default: v = $signed($urandom) >>> $urandom_range(2, 10);
		endcase
		return v;
	endfunction

	task automatic write_coef(input logic [3:0] mat, input coef_which_t w,
			input logic signed [31:0] v);
		req_t r;
		r = noise_req(CMD_COEF);
		r.coef_material = mat;
		r.coef_which = w;
		r.coef_value = v;
		send_request(r, 0);
	endtask

	task automatic send_update(input logic [11:0] cell_idx, input logic [3:0] mat,
			input logic signed [31:0] e, input int gap);
		req_t r;
		r = noise_req(CMD_UPDATE);
		r.cell_req = cell_idx;
		r.mat_x = mat;
		r.mat_y = mat;
		r.mat_z = mat;
		r.e_x = e;
		r.e_y = -e;
		r.e_z = e >>> 1;
		send_request(r, gap);
	endtask

	initial begin
		req_t r;
		int gap;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fill the whole coefficient table first: no material may be read unwritten
		for (int m = 0; m < 16; m++) begin
			write_coef(4'(m), CW_CFR, pick_coef());
			// materials 0 and 1 are real poles, imaginary parts zero
			write_coef(4'(m), CW_CFI, (m < 2) ? 32'sh0 : pick_coef());
			write_coef(4'(m), CW_CER, pick_coef());
			write_coef(4'(m), CW_CEI, (m < 2) ? 32'sh0 : pick_coef());
		end
		// material 15 at the coefficient rails to force saturation
		write_coef(4'd15, CW_CFR, 32'sh7fffffff);
		write_coef(4'd15, CW_CFI, 32'sh80000000);
		write_coef(4'd15, CW_CER, 32'sh7fffffff);
		write_coef(4'd15, CW_CEI, 32'sh80000000);

		// directed: field extremes, every command, both cell extremes
		send_update(12'd0, 4'd0, 32'sh7fffffff, 0);
		send_update(12'd0, 4'd0, 32'sh80000000, 0);
		send_update(12'd4095, 4'd15, 32'sh7fffffff, 0);
		send_update(12'd4095, 4'd15, 32'sh7fffffff, 0);
		send_update(12'd4095, 4'd15, 32'sh80000000, 3);
		send_update(12'd1, 4'd1, 32'sh0, 0);
		send_update(12'd2, 4'd2, 32'sh00400000, 0);
		send_update(12'd2, 4'd2, 32'sh00400000, 0);
		r = noise_req(CMD_FIELD);
		r.cell_req = 12'd4095;
		r.e_x = 32'sh7fffffff;
		r.e_y = 32'sh80000000;
		r.e_z = 32'sh0;
		send_request(r, 0);
		r.e_x = 32'sh80000000;
		r.e_y = 32'sh7fffffff;
		send_request(r, 0);
		r.cell_req = 12'd0;
		send_request(r, 2);
		send_request(noise_req(CMD_NOP), 0);
		send_request(noise_req(CMD_NOP), 1);
		// untouched cell reads back its reset value
		r = noise_req(CMD_FIELD);
		r.cell_req = 12'd3000;
		send_request(r, 0);

		// random part: updates and reads on hot cells, rewrites of live coefficients
		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i % 60 == 0)
				quiet = ($urandom_range(0, 2) == 0);
			if (i == RANDOM_REQS / 2) begin
				// drain: hold off until every outstanding response is back
				in_valid = 1'b0;
				while (pending != 0) @(negedge clk);
			end
			case ($urandom_range(0, 19))
				0, 1, 2:    r = noise_req(CMD_FIELD);
				3:          r = noise_req(CMD_COEF);
				4:          r = noise_req(CMD_NOP);
				default:    r = noise_req(CMD_UPDATE);
			endcase
			if ($urandom_range(0, 3) != 0)
				r.cell_req = hot_cells[$urandom_range(0, 7)];
			if (r.cmd == CMD_COEF && $urandom_range(0, 1) != 0)
				r.coef_value = pick_coef();
			if ($urandom_range(0, 3) != 0) begin
				r.e_x = pick_field();
				r.e_y = pick_field();
				r.e_z = pick_field();
			end
			gap = quiet ? 0 : $urandom_range(0, 11);
			send_request(r, gap);
		end
		in_valid = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);

		$display("covered %0d updates, %0d field reads, %0d coefficient writes, %0d no-ops",
			n_update, n_field, n_coef, n_nop);
		$display("with random gaps and stalls on both channels and one full drain");
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
